FILE: rtl/squarified_treemap_layout_core_assert.svh
// assertion macros for the treemap layout core
`ifndef SQUARIFIED_TREEMAP_LAYOUT_CORE_ASSERT_SVH
`define SQUARIFIED_TREEMAP_LAYOUT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define STL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STL_ASSERT_NOW(lbl, ante, cons, msg)
`define STL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/stl_pkg.sv
`default_nettype none
package stl_pkg;

  localparam int DEF_MAX_ITEMS = 64;
  localparam int DEF_FRAC_BITS = 16;

  localparam int VW     = 63;
  localparam int OW     = 33;
  localparam int WW     = 16;
  localparam int PW     = 32;
  localparam int WPW    = 48;
  localparam int QDEPTH = 4;

  localparam logic [VW-1:0] SATV    = {1'b1, {(VW-1){1'b0}}};
  localparam logic [OW-1:0] OUT_MAX = '1;

  localparam logic [1:0] KIND_ZERO  = 2'd0;
  localparam logic [1:0] KIND_STORE = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  localparam logic [1:0] CFG_AREA_W = 2'd0;
  localparam logic [1:0] CFG_AREA_H = 2'd1;
  localparam logic [1:0] CFG_ORG_X  = 2'd2;
  localparam logic [1:0] CFG_ORG_Y  = 2'd3;

  localparam logic [WW-1:0] RST_AREA_W = 16'd1024;
  localparam logic [WW-1:0] RST_AREA_H = 16'd768;

  typedef struct packed {
    logic [WW-1:0] weight;
    logic          last_weight;
  } in_item_t;

  typedef struct packed {
    logic [OW-1:0] x_left;
    logic [OW-1:0] y_top;
    logic [OW-1:0] x_right;
    logic [OW-1:0] y_bottom;
    logic          last_rect;
    logic          too_many;
  } out_item_t;

  typedef struct packed {
    logic [WW-1:0] weight;
    logic          last;
    logic [1:0]    kind;
  } cmd_t;

  typedef struct packed {
    logic          start;
    logic          op;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [VW-1:0] res;
  } arith_rsp_t;

  typedef struct packed {
    logic [WW-1:0] area_width;
    logic [WW-1:0] area_height;
    logic [WW-1:0] origin_x;
    logic [WW-1:0] origin_y;
  } cfg_t;

  function automatic logic [VW-1:0] sadd(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SATV}) ? SATV : s[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] vmin(input logic [VW-1:0] a, input logic [VW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [VW-1:0] vmax(input logic [VW-1:0] a, input logic [VW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [OW-1:0] clampo(input logic [VW-1:0] v);
    return (v > VW'(OUT_MAX)) ? OUT_MAX : v[OW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/stl_front.sv
`default_nettype none
module stl_front import stl_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output cmd_t          cmd
);

  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int QAW = $clog2(QDEPTH);
  localparam int QFW = $clog2(QDEPTH + 1);

  cmd_t           q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QFW-1:0] fill_r, fill_nxt;
  logic [CW-1:0]  fcnt_r, fcnt_nxt;
  logic           push, pop;
  cmd_t           cmd_in;

  assign in_stall  = (fill_r == QFW'(QDEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_mem[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_valid && cmd_ready;

  // sort each beat into stored, dropped or ignored by a running count of the set
  always_comb begin
    cmd_in.weight = in_data.weight;
    cmd_in.last   = in_data.last_weight;
    fcnt_nxt      = fcnt_r;
    if (in_data.weight == '0) begin
      cmd_in.kind = KIND_ZERO;
    end else if (fcnt_r == CW'(MAX_ITEMS)) begin
      cmd_in.kind = KIND_DROP;
    end else begin
      cmd_in.kind = KIND_STORE;
      fcnt_nxt    = fcnt_r + CW'(1);
    end
    if (in_data.last_weight) begin
      fcnt_nxt = '0;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + QFW'(1);
      2'b01:   fill_nxt = fill_r - QFW'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      fcnt_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      if (push) begin
        fcnt_r <= fcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stl_arith.sv
`default_nettype none
module stl_arith import stl_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire arith_req_t req,
  output arith_rsp_t      rsp
);

  localparam int NW   = VW + FRAC_BITS;
  localparam int AW   = VW + 1 + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);
  localparam logic [AW-1:0] CAP = {1'b1, {(AW-1){1'b0}}};

  logic            busy_r, done_r, op_r;
  logic [CNTW-1:0] cnt_r;
  logic [VW-1:0]   b_r, rem_r, ma_r, mb_r;
  logic [NW-1:0]   num_r, quot_r;
  logic [AW-1:0]   acc_r;
  logic [VW:0]     r2;
  logic            ge;
  logic [VW:0]     rdiff;
  logic [AW:0]     msum;
  logic [VW:0]     accs;

  // restoring divide: one quotient bit a cycle
  assign r2    = {rem_r, num_r[NW-1]};
  assign ge    = (r2 >= {1'b0, b_r});
  assign rdiff = r2 - {1'b0, b_r};
  // shift-add multiply, msb of the multiplier first, held at a ceiling
  assign msum  = {acc_r, 1'b0} + (mb_r[VW-1] ? (AW+1)'(ma_r) : '0);
  assign accs  = acc_r[AW-1:FRAC_BITS];

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    if (op_r == OP_MUL) begin
      rsp.res = (accs > {1'b0, SATV}) ? SATV : accs[VW-1:0];
    end else if (b_r == '0) begin
      rsp.res = SATV;
    end else begin
      rsp.res = (quot_r > NW'(SATV)) ? SATV : quot_r[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == OP_MUL) ? CNTW'(VW) : CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r   <= req.op;
      b_r    <= req.b;
      num_r  <= NW'(req.a) << FRAC_BITS;
      rem_r  <= '0;
      quot_r <= '0;
      ma_r   <= req.a;
      mb_r   <= req.b;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        acc_r <= (msum > (AW+1)'(CAP)) ? CAP : msum[AW-1:0];
        mb_r  <= mb_r << 1;
      end else begin
        rem_r  <= ge ? rdiff[VW-1:0] : r2[VW-1:0];
        num_r  <= num_r << 1;
        quot_r <= {quot_r[NW-2:0], ge};
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stl_back.sv
`default_nettype none
module stl_back import stl_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire cmd_t       cmd,
  output arith_req_t      areq,
  input  wire arith_rsp_t arsp,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  `include "squarified_treemap_layout_core_assert.svh"

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int TW = $clog2(MAX_ITEMS * 65535 + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INIT    = 5'd1;
  localparam logic [4:0] S_A_RD    = 5'd2;
  localparam logic [4:0] S_A_MUL   = 5'd3;
  localparam logic [4:0] S_A_DIV   = 5'd4;
  localparam logic [4:0] S_WAIT    = 5'd5;
  localparam logic [4:0] S_M_GOT   = 5'd6;
  localparam logic [4:0] S_W_D     = 5'd7;
  localparam logic [4:0] S_W_D2    = 5'd8;
  localparam logic [4:0] S_W_T1    = 5'd9;
  localparam logic [4:0] S_W_T2    = 5'd10;
  localparam logic [4:0] S_W_END   = 5'd11;
  localparam logic [4:0] S_NEXT    = 5'd12;
  localparam logic [4:0] S_R_START = 5'd13;
  localparam logic [4:0] S_R_T     = 5'd14;
  localparam logic [4:0] S_R_LEN   = 5'd15;
  localparam logic [4:0] S_R_OUT   = 5'd16;

  logic [WW-1:0]  mem [MAX_ITEMS];
  logic [WW-1:0]  rd_r;
  logic           mem_we;

  logic [4:0]     state_r, state_nxt, ret_r, ret_nxt, reta_r, reta_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [TW-1:0]  tot_r, tot_nxt;
  logic           ovf_r, ovf_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic [WPW-1:0] wp_r, wp_nxt;
  logic [VW-1:0]  cx_r, cx_nxt, cy_r, cy_nxt, cw_r, cw_nxt, ch_r, ch_nxt;
  logic [VW-1:0]  rs_r, rs_nxt, mn_r, mn_nxt, mx_r, mx_nxt, a_r, a_nxt;
  logic [VW-1:0]  wa_r, wa_nxt, t1_r, t1_nxt, d2_r, d2_nxt;
  logic [VW-1:0]  t_r, t_nxt, pos_r, pos_nxt;
  logic [CW-1:0]  i_r, i_nxt, first_r, first_nxt, k_r, k_nxt, end_r, end_nxt;
  logic           sel_r, sel_nxt, wide_r, wide_nxt, final_r, final_nxt;
  logic           ob_valid_r, ob_load;
  out_item_t      ob_r, ob_nxt;

  logic [VW-1:0]  edge_v, ns_v, nmn_v, nmx_v, s_sel, mn_sel, mx_sel, wv_v;
  logic [VW-1:0]  npos_v, xr_v, yb_v;
  logic           ob_free, k_last, i_last, row_end;

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = ob_valid_r;
  assign out_data  = ob_r;
  assign ob_free   = !ob_valid_r || !out_stall;

  assign edge_v = vmin(cw_r, ch_r);
  assign ns_v   = sadd(rs_r, a_r);
  assign nmn_v  = vmin(a_r, mn_r);
  assign nmx_v  = vmax(a_r, mx_r);
  assign s_sel  = sel_r ? ns_v  : rs_r;
  assign mn_sel = sel_r ? nmn_v : mn_r;
  assign mx_sel = sel_r ? nmx_v : mx_r;
  assign wv_v   = vmax(t1_r, arsp.res);
  assign npos_v = sadd(pos_r, arsp.res);
  assign xr_v   = sadd(cx_r, t_r);
  assign yb_v   = sadd(cy_r, t_r);
  assign k_last = ((k_r + CW'(1)) == end_r);
  assign i_last = ((i_r + CW'(1)) == cnt_r);
  assign row_end = final_r && k_last;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    reta_nxt  = reta_r;
    cnt_nxt   = cnt_r;
    tot_nxt   = tot_r;
    ovf_nxt   = ovf_r;
    prod_nxt  = prod_r;
    wp_nxt    = wp_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cw_nxt    = cw_r;
    ch_nxt    = ch_r;
    rs_nxt    = rs_r;
    mn_nxt    = mn_r;
    mx_nxt    = mx_r;
    a_nxt     = a_r;
    wa_nxt    = wa_r;
    t1_nxt    = t1_r;
    d2_nxt    = d2_r;
    t_nxt     = t_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    first_nxt = first_r;
    k_nxt     = k_r;
    end_nxt   = end_r;
    sel_nxt   = sel_r;
    wide_nxt  = wide_r;
    final_nxt = final_r;
    mem_we    = 1'b0;
    ob_load   = 1'b0;
    ob_nxt    = ob_r;
    areq      = '0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == KIND_STORE) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            tot_nxt = tot_r + TW'(cmd.weight);
          end else if (cmd.kind == KIND_DROP) begin
            ovf_nxt = 1'b1;
          end
          if (cmd.last) begin
            if (cmd.kind == KIND_STORE || cnt_r != '0) begin
              state_nxt = S_INIT;
            end else begin
              cnt_nxt = '0;
              tot_nxt = '0;
              ovf_nxt = 1'b0;
            end
          end
        end
      end
      S_INIT: begin
        prod_nxt  = PW'(cfg.area_width) * PW'(cfg.area_height);
        cx_nxt    = VW'(cfg.origin_x) << FRAC_BITS;
        cy_nxt    = VW'(cfg.origin_y) << FRAC_BITS;
        cw_nxt    = VW'(cfg.area_width) << FRAC_BITS;
        ch_nxt    = VW'(cfg.area_height) << FRAC_BITS;
        i_nxt     = '0;
        first_nxt = '0;
        k_nxt     = '0;
        reta_nxt  = S_M_GOT;
        state_nxt = S_A_RD;
      end
      S_A_RD: begin
        state_nxt = S_A_MUL;
      end
      S_A_MUL: begin
        wp_nxt    = WPW'(rd_r) * WPW'(prod_r);
        state_nxt = S_A_DIV;
      end
      S_A_DIV: begin
        areq.start = 1'b1;
        areq.op    = OP_DIV;
        areq.a     = VW'(wp_r);
        areq.b     = VW'(tot_r);
        ret_nxt    = reta_r;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (arsp.done) begin
          state_nxt = ret_r;
        end
      end
      S_M_GOT: begin
        a_nxt = arsp.res;
        if (i_r == first_r) begin
          rs_nxt    = arsp.res;
          mn_nxt    = arsp.res;
          mx_nxt    = arsp.res;
          state_nxt = S_NEXT;
        end else begin
          sel_nxt   = 1'b0;
          state_nxt = S_W_D;
        end
      end
      // worst ratio of the row, first as it stands, then with the new area
      S_W_D: begin
        areq.start = 1'b1;
        areq.op    = OP_DIV;
        areq.a     = s_sel;
        areq.b     = edge_v;
        ret_nxt    = S_W_D2;
        state_nxt  = S_WAIT;
      end
      S_W_D2: begin
        areq.start = 1'b1;
        areq.op    = OP_MUL;
        areq.a     = arsp.res;
        areq.b     = arsp.res;
        ret_nxt    = S_W_T1;
        state_nxt  = S_WAIT;
      end
      S_W_T1: begin
        d2_nxt     = arsp.res;
        areq.start = 1'b1;
        areq.op    = OP_DIV;
        areq.a     = mx_sel;
        areq.b     = arsp.res;
        ret_nxt    = S_W_T2;
        state_nxt  = S_WAIT;
      end
      S_W_T2: begin
        t1_nxt     = arsp.res;
        areq.start = 1'b1;
        areq.op    = OP_DIV;
        areq.a     = d2_r;
        areq.b     = mn_sel;
        ret_nxt    = S_W_END;
        state_nxt  = S_WAIT;
      end
      S_W_END: begin
        if (!sel_r) begin
          wa_nxt    = wv_v;
          sel_nxt   = 1'b1;
          state_nxt = S_W_D;
        end else if (wa_r >= wv_v) begin
          rs_nxt    = ns_v;
          mn_nxt    = nmn_v;
          mx_nxt    = nmx_v;
          state_nxt = S_NEXT;
        end else begin
          end_nxt   = i_r;
          final_nxt = 1'b0;
          state_nxt = S_R_START;
        end
      end
      S_NEXT: begin
        if (i_last) begin
          end_nxt   = cnt_r;
          final_nxt = 1'b1;
          state_nxt = S_R_START;
        end else begin
          i_nxt     = i_r + CW'(1);
          k_nxt     = i_r + CW'(1);
          reta_nxt  = S_M_GOT;
          state_nxt = S_A_RD;
        end
      end
      S_R_START: begin
        wide_nxt   = (cw_r >= ch_r);
        areq.start = 1'b1;
        areq.op    = OP_DIV;
        areq.a     = rs_r;
        areq.b     = (cw_r >= ch_r) ? ch_r : cw_r;
        ret_nxt    = S_R_T;
        state_nxt  = S_WAIT;
      end
      S_R_T: begin
        t_nxt     = arsp.res;
        pos_nxt   = wide_r ? cy_r : cx_r;
        k_nxt     = first_r;
        reta_nxt  = S_R_LEN;
        state_nxt = S_A_RD;
      end
      S_R_LEN: begin
        areq.start = 1'b1;
        areq.op    = OP_DIV;
        areq.a     = arsp.res;
        areq.b     = t_r;
        ret_nxt    = S_R_OUT;
        state_nxt  = S_WAIT;
      end
      S_R_OUT: begin
        if (ob_free) begin
          ob_load = 1'b1;
          if (wide_r) begin
            ob_nxt.x_left   = clampo(cx_r);
            ob_nxt.y_top    = clampo(pos_r);
            ob_nxt.x_right  = clampo(xr_v);
            ob_nxt.y_bottom = clampo(npos_v);
          end else begin
            ob_nxt.x_left   = clampo(pos_r);
            ob_nxt.y_top    = clampo(cy_r);
            ob_nxt.x_right  = clampo(npos_v);
            ob_nxt.y_bottom = clampo(yb_v);
          end
          ob_nxt.last_rect = row_end;
          ob_nxt.too_many  = row_end && ovf_r;
          pos_nxt = npos_v;
          if (k_last) begin
            if (final_r) begin
              cnt_nxt   = '0;
              tot_nxt   = '0;
              ovf_nxt   = 1'b0;
              state_nxt = S_IDLE;
            end else begin
              // cut the closed row from the container
              if (wide_r) begin
                cx_nxt = xr_v;
                cw_nxt = (cw_r > t_r) ? cw_r - t_r : '0;
              end else begin
                cy_nxt = yb_v;
                ch_nxt = (ch_r > t_r) ? ch_r - t_r : '0;
              end
              first_nxt = i_r;
              rs_nxt    = a_r;
              mn_nxt    = a_r;
              mx_nxt    = a_r;
              state_nxt = S_NEXT;
            end
          end else begin
            k_nxt     = k_r + CW'(1);
            reta_nxt  = S_R_LEN;
            state_nxt = S_A_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      reta_r     <= S_IDLE;
      cnt_r      <= '0;
      tot_r      <= '0;
      ovf_r      <= 1'b0;
      ob_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      reta_r  <= reta_nxt;
      cnt_r   <= cnt_nxt;
      tot_r   <= tot_nxt;
      ovf_r   <= ovf_nxt;
      if (ob_load) begin
        ob_valid_r <= 1'b1;
      end else if (!out_stall) begin
        ob_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    wp_r    <= wp_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cw_r    <= cw_nxt;
    ch_r    <= ch_nxt;
    rs_r    <= rs_nxt;
    mn_r    <= mn_nxt;
    mx_r    <= mx_nxt;
    a_r     <= a_nxt;
    wa_r    <= wa_nxt;
    t1_r    <= t1_nxt;
    d2_r    <= d2_nxt;
    t_r     <= t_nxt;
    pos_r   <= pos_nxt;
    i_r     <= i_nxt;
    first_r <= first_nxt;
    k_r     <= k_nxt;
    end_r   <= end_nxt;
    sel_r   <= sel_nxt;
    wide_r  <= wide_nxt;
    final_r <= final_nxt;
    ob_r    <= ob_nxt;
  end

  // weight store: write at the fill count, read at the scan index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IW-1:0]] <= cmd.weight;
    end
    rd_r <= mem[k_r[IW-1:0]];
  end

  `STL_ASSERT_NOW(a_no_restart, arsp.busy, !areq.start,
    "arith unit started while busy")
  `STL_ASSERT_NOW(a_wait_live, state_r == S_WAIT, arsp.busy || arsp.done,
    "waiting on an idle arith unit")
  `STL_ASSERT_NOW(a_store_room, (state_r == S_IDLE) && cmd_valid && (cmd.kind == KIND_STORE),
    cnt_r < CW'(MAX_ITEMS), "front classified a store into a full set")
  `STL_ASSERT_NEXT(a_layout_clears, (state_r == S_R_OUT) && ob_free && row_end,
    (cnt_r == '0) && (state_r == S_IDLE), "set not cleared after final rectangle")

endmodule
`default_nettype wire

FILE: rtl/squarified_treemap_layout_core.sv
`default_nettype none
// Squarified treemap layout. Weights arrive one beat per cycle while in_stall
// is low and are stored (up to MAX_ITEMS; extra ones are dropped and flagged
// as too_many on the final rectangle); a beat with last_weight set lays the
// set out over the configured rectangle in arrival order, one
// Q(33-FRAC_BITS).FRAC_BITS rectangle per stored weight. Loading runs at one
// beat per cycle through a four-entry command queue while the layout is idle.
// Layout is done on a single shared bit-serial unit: each weight after the
// first of a row scan needs nine divides and two multiplies (scaled area
// twice, two worst-ratio checks, its length in the row), plus one more divide
// for the thickness of each row. Configuration must be written only when
// idle; the block itself does not enforce this. Zero weights are ignored.
module squarified_treemap_layout_core import stl_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [WW-1:0] cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_item_t      in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output out_item_t          out_data
);

  cfg_t       cfg_r;
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;
  arith_req_t areq;
  arith_rsp_t arsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.area_width  <= RST_AREA_W;
      cfg_r.area_height <= RST_AREA_H;
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AREA_W: cfg_r.area_width  <= cfg_wdata;
        CFG_AREA_H: cfg_r.area_height <= cfg_wdata;
        CFG_ORG_X:  cfg_r.origin_x    <= cfg_wdata;
        CFG_ORG_Y:  cfg_r.origin_y    <= cfg_wdata;
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  stl_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  stl_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  stl_back #(
    .MAX_ITEMS (MAX_ITEMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .areq      (areq),
    .arsp      (arsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
